### rtl/wsp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the world-to-screen projection.
// No dependencies; every other file imports this package.
package wsp_pkg;

   // Default parameter values for the top level
   localparam int COORD_WIDTH_DEF    = 24;
   localparam int COEF_FRAC_BITS_DEF = 16;

   // Fixed widths of the datapath
   localparam int COEF_WIDTH      = 32;
   localparam int ACC_WIDTH       = 64;
   localparam int DIV_WIDTH       = ACC_WIDTH - 1;
   localparam int RES_WIDTH       = 14;
   localparam int QUO_BITS        = 19;
   localparam int A_WIDTH         = QUO_BITS + 1;
   localparam int RATIO_LIM       = 1 << (QUO_BITS - 1);
   localparam int SUM_WIDTH       = RES_WIDTH + A_WIDTH + 2;
   localparam int PIX_WIDTH       = 16;
   localparam int ROWS            = 3;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 64;

   localparam logic [RES_WIDTH-1:0] WIDTH_RESET  = RES_WIDTH'(1920);
   localparam logic [RES_WIDTH-1:0] HEIGHT_RESET = RES_WIDTH'(1080);

   // Register map
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_ROW0_LOW      = 4'd0,
      REG_ROW0_HIGH     = 4'd1,
      REG_ROW1_LOW      = 4'd2,
      REG_ROW1_HIGH     = 4'd3,
      REG_ROW3_LOW      = 4'd4,
      REG_ROW3_HIGH     = 4'd5,
      REG_SCREEN_WIDTH  = 4'd6,
      REG_SCREEN_HEIGHT = 4'd7
   } csr_reg_type;

   // One matrix row: three coefficients and the offset, Q16.16 by default
   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] off;
      logic signed [COEF_WIDTH-1:0] mz;
      logic signed [COEF_WIDTH-1:0] my;
      logic signed [COEF_WIDTH-1:0] mx;
   } row_type;

   // Control bits that travel with each transaction
   typedef struct packed {
      logic valid;
      logic visible;
   } tag_type;

   // Add two accumulator words, clamping at the signed limits
   function automatic logic signed [ACC_WIDTH-1:0] sat_add(
      input logic signed [ACC_WIDTH-1:0] a,
      input logic signed [ACC_WIDTH-1:0] b
   );
      logic signed [ACC_WIDTH:0] s;
      s = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
      if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
         sat_add = s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end else begin
         sat_add = s[ACC_WIDTH-1:0];
      end
   endfunction

   // Clamp a pixel sum to the signed output range
   function automatic logic signed [PIX_WIDTH-1:0] sat_pix(
      input logic signed [SUM_WIDTH-1:0] v
   );
      logic signed [SUM_WIDTH-1:0] hi;
      logic signed [SUM_WIDTH-1:0] lo;
      hi = SUM_WIDTH'((1 << (PIX_WIDTH - 1)) - 1);
      lo = -hi - SUM_WIDTH'(1);
      if (v > hi) begin
         sat_pix = hi[PIX_WIDTH-1:0];
      end else if (v < lo) begin
         sat_pix = lo[PIX_WIDTH-1:0];
      end else begin
         sat_pix = v[PIX_WIDTH-1:0];
      end
   endfunction

endpackage

### rtl/wsp_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the projection block: point requests, pixel responses
// and register writes. Depends on wsp_pkg.
interface wsp_req_if import wsp_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] world_x;
   logic signed [COORD_WIDTH-1:0] world_y;
   logic signed [COORD_WIDTH-1:0] world_z;
   modport source (output valid, world_x, world_y, world_z, input ready);
   modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

interface wsp_rsp_if import wsp_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic                        visible;
   logic signed [PIX_WIDTH-1:0] screen_x;
   logic signed [PIX_WIDTH-1:0] screen_y;
   modport source (output valid, visible, screen_x, screen_y, input ready);
   modport sink   (input valid, visible, screen_x, screen_y, output ready);
endinterface

interface wsp_csr_if import wsp_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/wsp_clip.sv
`timescale 1ns / 1ps
// Clip-space stage: three dot products plus offsets with saturating sums.
// Depends on wsp_pkg.
module wsp_clip import wsp_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] x,
   input  logic signed [COORD_WIDTH-1:0] y,
   input  logic signed [COORD_WIDTH-1:0] z,
   input  row_type [ROWS-1:0]            rows,
   output logic                          out_valid,
   output logic [ROWS-1:0][ACC_WIDTH-1:0] clip
);
   localparam int PROD_WIDTH = COEF_WIDTH + COORD_WIDTH;
   localparam int DEPTH      = 4;

   logic [DEPTH-1:0] valid_ff;

   // Advance the valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[DEPTH-1];

   for (genvar r = 0; r < ROWS; r++) begin : g_row
      logic signed [PROD_WIDTH-1:0] px_ff;
      logic signed [PROD_WIDTH-1:0] py_ff;
      logic signed [PROD_WIDTH-1:0] pz_ff;
      logic signed [PROD_WIDTH-1:0] pz2_ff;
      logic signed [ACC_WIDTH-1:0]  s1_ff;
      logic signed [ACC_WIDTH-1:0]  s2_ff;
      logic signed [ACC_WIDTH-1:0]  s3_ff;

      // Products, then three saturating additions in model order
      always_ff @(posedge clock) begin
         if (en) begin
            px_ff  <= rows[r].mx * x;
            py_ff  <= rows[r].my * y;
            pz_ff  <= rows[r].mz * z;
            s1_ff  <= sat_add(ACC_WIDTH'(px_ff), ACC_WIDTH'(py_ff));
            pz2_ff <= pz_ff;
            s2_ff  <= sat_add(s1_ff, ACC_WIDTH'(pz2_ff));
            s3_ff  <= sat_add(s2_ff, ACC_WIDTH'(rows[r].off));
         end
      end

      assign clip[r] = s3_ff;
   end

endmodule

### rtl/wsp_ratio.sv
`timescale 1ns / 1ps
// Floor division of clip x and clip y by w: clamped quotient and remainder,
// one restoring step per stage. Depends on wsp_pkg.
module wsp_ratio import wsp_pkg::*; #(
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [ROWS-1:0][ACC_WIDTH-1:0] clip,
   output tag_type                        out_tag,
   output logic [1:0][A_WIDTH-1:0]        ratio_a,
   output logic [1:0][DIV_WIDTH-1:0]      ratio_r,
   output logic [DIV_WIDTH-1:0]           w_out
);
   // Smallest raw w that counts as 0.01 or more
   localparam logic signed [ACC_WIDTH-1:0] W_MIN =
      ACC_WIDTH'(((longint'(1) << COEF_FRAC_BITS) + 99) / 100);
   localparam logic signed [QUO_BITS+1:0] LIM_HI = (QUO_BITS+2)'(RATIO_LIM);
   localparam logic signed [QUO_BITS+1:0] LIM_LO = -LIM_HI;

   tag_type                  tag_ff [QUO_BITS+1];
   logic [DIV_WIDTH-1:0]     w_ff   [QUO_BITS+1];
   tag_type                  tag_out_ff;
   logic [DIV_WIDTH-1:0]     w_out_ff;

   // Entry: visibility test, w captured for the steps
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[0] <= '0;
      end else if (en) begin
         tag_ff[0].valid   <= in_valid;
         tag_ff[0].visible <= $signed(clip[2]) >= W_MIN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff[0] <= clip[2][DIV_WIDTH-1:0];
      end
   end

   // Carry tags and w along the division steps
   for (genvar i = 0; i < QUO_BITS; i++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[i+1] <= '0;
         end else if (en) begin
            tag_ff[i+1] <= tag_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            w_ff[i+1] <= w_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_out_ff <= '0;
      end else if (en) begin
         tag_out_ff <= tag_ff[QUO_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_out_ff <= w_ff[QUO_BITS];
      end
   end

   assign out_tag = tag_out_ff;
   assign w_out   = w_out_ff;

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DIV_WIDTH-1:0] rem_ff [QUO_BITS+1];
      logic [QUO_BITS-1:0]  low_ff [QUO_BITS+1];
      logic [QUO_BITS-1:0]  quo_ff [QUO_BITS+1];
      logic                 neg_ff [QUO_BITS+1];
      logic                 ovf_ff [QUO_BITS+1];
      logic [DIV_WIDTH-1:0] mag;
      logic                 ovf_in;
      logic [QUO_BITS-1:0]  q_fin;
      logic signed [QUO_BITS+1:0] a_raw;
      logic signed [QUO_BITS+1:0] a_in;
      logic [DIV_WIDTH-1:0] r_in;
      logic [A_WIDTH-1:0]   a_ff;
      logic [DIV_WIDTH-1:0] r_ff;

      // Negative dividends are divided as their complement
      assign mag    = clip[l][ACC_WIDTH-1] ? ~clip[l][DIV_WIDTH-1:0]
                                           : clip[l][DIV_WIDTH-1:0];
      assign ovf_in = (mag >> QUO_BITS) >= clip[2][DIV_WIDTH-1:0];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[0] <= ovf_in ? '0 : (mag >> QUO_BITS);
            low_ff[0] <= mag[QUO_BITS-1:0];
            quo_ff[0] <= '0;
            neg_ff[0] <= clip[l][ACC_WIDTH-1];
            ovf_ff[0] <= ovf_in;
         end
      end

      // One quotient bit per stage
      for (genvar i = 0; i < QUO_BITS; i++) begin : g_step
         logic [DIV_WIDTH:0] t_in;
         logic               ge;
         assign t_in = {rem_ff[i], low_ff[i][QUO_BITS-1-i]};
         assign ge   = t_in >= {1'b0, w_ff[i]};
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i+1] <= ge ? DIV_WIDTH'(t_in - {1'b0, w_ff[i]})
                                 : t_in[DIV_WIDTH-1:0];
               low_ff[i+1] <= low_ff[i];
               quo_ff[i+1] <= {quo_ff[i][QUO_BITS-2:0], ge};
               neg_ff[i+1] <= neg_ff[i];
               ovf_ff[i+1] <= ovf_ff[i];
            end
         end
      end

      // Restore the sign: floor(-n-1 / w) = -(q+1), remainder w-1-s
      assign q_fin = ovf_ff[QUO_BITS] ? '1 : quo_ff[QUO_BITS];
      assign a_raw = neg_ff[QUO_BITS] ? ~{2'b00, q_fin} : {2'b00, q_fin};
      assign a_in  = (a_raw > LIM_HI) ? LIM_HI : ((a_raw < LIM_LO) ? LIM_LO : a_raw);
      assign r_in  = neg_ff[QUO_BITS]
                   ? w_ff[QUO_BITS] - DIV_WIDTH'(1) - rem_ff[QUO_BITS]
                   : rem_ff[QUO_BITS];

      always_ff @(posedge clock) begin
         if (en) begin
            a_ff <= A_WIDTH'(a_in);
            r_ff <= r_in;
         end
      end

      assign ratio_a[l] = a_ff;
      assign ratio_r[l] = r_ff;
   end

endmodule

### rtl/wsp_pixel.sv
`timescale 1ns / 1ps
// Pixel stage: scales the division remainder by the resolution, divides by w
// one bit per stage and forms the saturated screen coordinates. Depends on wsp_pkg.
module wsp_pixel import wsp_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  tag_type                        in_tag,
   input  logic [1:0][A_WIDTH-1:0]        ratio_a,
   input  logic [1:0][DIV_WIDTH-1:0]      ratio_r,
   input  logic [DIV_WIDTH-1:0]           w_in,
   input  logic [1:0][RES_WIDTH-1:0]      res,
   output logic                           out_valid,
   output logic                           out_visible,
   output logic signed [PIX_WIDTH-1:0]    screen_x,
   output logic signed [PIX_WIDTH-1:0]    screen_y
);
   localparam int PROD_WIDTH = RES_WIDTH + DIV_WIDTH;

   tag_type              tag_ff [RES_WIDTH+1];
   logic [DIV_WIDTH-1:0] w_ff   [RES_WIDTH+1];
   tag_type              tag_out_ff;
   logic [1:0][PIX_WIDTH-1:0] pix_in;
   logic [1:0][PIX_WIDTH-1:0] pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[0] <= '0;
      end else if (en) begin
         tag_ff[0] <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff[0] <= w_in;
      end
   end

   for (genvar i = 0; i < RES_WIDTH; i++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[i+1] <= '0;
         end else if (en) begin
            tag_ff[i+1] <= tag_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            w_ff[i+1] <= w_ff[i];
         end
      end
   end

   // Lane 0 gives screen x, lane 1 screen y
   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DIV_WIDTH-1:0]        rem_ff  [RES_WIDTH+1];
      logic [RES_WIDTH-1:0]        low_ff  [RES_WIDTH+1];
      logic [RES_WIDTH-1:0]        quo_ff  [RES_WIDTH+1];
      logic signed [SUM_WIDTH-1:0] base_ff [RES_WIDTH+1];
      logic [PROD_WIDTH-1:0]       prod_in;
      logic signed [A_WIDTH:0]     a_ext;
      logic signed [A_WIDTH:0]     am;
      logic signed [SUM_WIDTH-1:0] base_in;
      logic signed [SUM_WIDTH-1:0] q_ext;
      logic                        inexact;
      logic signed [SUM_WIDTH-1:0] sum;

      // Multiply: res * r for the fraction, res * (1 +/- a) for the whole part
      assign prod_in = res[l] * ratio_r[l];
      assign a_ext   = (A_WIDTH+1)'($signed(ratio_a[l]));
      assign am      = (l == 0) ? a_ext + (A_WIDTH+1)'(1) : (A_WIDTH+1)'(1) - a_ext;
      assign base_in = $signed({1'b0, res[l]}) * am;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[0]  <= prod_in[PROD_WIDTH-1:RES_WIDTH];
            low_ff[0]  <= prod_in[RES_WIDTH-1:0];
            quo_ff[0]  <= '0;
            base_ff[0] <= base_in;
         end
      end

      for (genvar i = 0; i < RES_WIDTH; i++) begin : g_step
         logic [DIV_WIDTH:0] t_in;
         logic               ge;
         assign t_in = {rem_ff[i], low_ff[i][RES_WIDTH-1-i]};
         assign ge   = t_in >= {1'b0, w_ff[i]};
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i+1]  <= ge ? DIV_WIDTH'(t_in - {1'b0, w_ff[i]})
                                  : t_in[DIV_WIDTH-1:0];
               low_ff[i+1]  <= low_ff[i];
               quo_ff[i+1]  <= {quo_ff[i][RES_WIDTH-2:0], ge};
               base_ff[i+1] <= base_ff[i];
            end
         end
      end

      // x: floor((W*(a+1) + 1 + q) / 2); y: floor((H*(1-a) - 1 - q - inexact) / 2)
      assign q_ext   = SUM_WIDTH'(quo_ff[RES_WIDTH]);
      assign inexact = |rem_ff[RES_WIDTH];
      assign sum     = (l == 0)
                     ? base_ff[RES_WIDTH] + SUM_WIDTH'(1) + q_ext
                     : base_ff[RES_WIDTH] - SUM_WIDTH'(1) - q_ext - SUM_WIDTH'(inexact);
      assign pix_in[l] = tag_ff[RES_WIDTH].visible ? sat_pix(sum >>> 1) : '0;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_out_ff <= '0;
      end else if (en) begin
         tag_out_ff <= tag_ff[RES_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pix_ff <= pix_in;
      end
   end

   assign out_valid   = tag_out_ff.valid;
   assign out_visible = tag_out_ff.visible;
   assign screen_x    = $signed(pix_ff[0]);
   assign screen_y    = $signed(pix_ff[1]);

endmodule

### rtl/world_to_screen_projection.sv
`timescale 1ns / 1ps
// World-to-screen projection top level: register file, stall control and the
// clip, ratio and pixel pipelines. Depends on wsp_pkg, wsp_if and the wsp_ submodules.
//
// Usage:
//   req_chan carries a world point (world_x, world_y, world_z). rsp_chan returns one
//   transaction per point: visible, screen_x, screen_y. Points behind the camera
//   (w below 0.01) come back with visible low and both coordinates zero.
//   csr_chan writes the matrix rows 0, 1 and 3 and the screen size; it is always
//   ready and must only be used while no point is in flight.
// Pipeline:
//   A point accepted on req_chan passes through the products and sums, the floor
//   division by w (one quotient bit a stage) and the resolution scaling and the
//   pixel sums before it leaves on rsp_chan. One point is accepted every cycle
//   while no result is held on rsp_chan.
// Reset:
//   Synchronous reset empties the pipeline, zeroes the matrix and sets the
//   screen to 1920 by 1080.
// Back-pressure:
//   While a result waits with rsp_chan.ready low, the whole pipeline holds and
//   req_chan.ready drops; nothing is lost or repeated.
module world_to_screen_projection import wsp_pkg::*; #(
   parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   wsp_req_if.sink    req_chan,
   wsp_rsp_if.source  rsp_chan,
   wsp_csr_if.sink    csr_chan
);
   logic [CSR_DATA_WIDTH-1:0] row0_lo_ff, row0_hi_ff;
   logic [CSR_DATA_WIDTH-1:0] row1_lo_ff, row1_hi_ff;
   logic [CSR_DATA_WIDTH-1:0] row3_lo_ff, row3_hi_ff;
   logic [RES_WIDTH-1:0]      width_ff, height_ff;

   row_type [ROWS-1:0]            rows;
   logic                          en;
   logic                          clip_valid;
   logic [ROWS-1:0][ACC_WIDTH-1:0] clip;
   tag_type                       ratio_tag;
   logic [1:0][A_WIDTH-1:0]       ratio_a;
   logic [1:0][DIV_WIDTH-1:0]     ratio_r;
   logic [DIV_WIDTH-1:0]          ratio_w;
   logic                          out_valid;

   // Register writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_lo_ff <= '0;
         row0_hi_ff <= '0;
         row1_lo_ff <= '0;
         row1_hi_ff <= '0;
         row3_lo_ff <= '0;
         row3_hi_ff <= '0;
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
      end else if (csr_chan.valid) begin
         case (csr_reg_type'(csr_chan.index))
            REG_ROW0_LOW:      row0_lo_ff <= csr_chan.data;
            REG_ROW0_HIGH:     row0_hi_ff <= csr_chan.data;
            REG_ROW1_LOW:      row1_lo_ff <= csr_chan.data;
            REG_ROW1_HIGH:     row1_hi_ff <= csr_chan.data;
            REG_ROW3_LOW:      row3_lo_ff <= csr_chan.data;
            REG_ROW3_HIGH:     row3_hi_ff <= csr_chan.data;
            REG_SCREEN_WIDTH:  width_ff   <= csr_chan.data[RES_WIDTH-1:0];
            REG_SCREEN_HEIGHT: height_ff  <= csr_chan.data[RES_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rows[0] = row_type'({row0_hi_ff, row0_lo_ff});
   assign rows[1] = row_type'({row1_hi_ff, row1_lo_ff});
   assign rows[2] = row_type'({row3_hi_ff, row3_lo_ff});

   // Advance every stage unless the output transaction is held
   assign en             = !out_valid || rsp_chan.ready;
   assign req_chan.ready = en;

   wsp_clip #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_clip (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .x         (req_chan.world_x),
      .y         (req_chan.world_y),
      .z         (req_chan.world_z),
      .rows      (rows),
      .out_valid (clip_valid),
      .clip      (clip)
   );

   wsp_ratio #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_ratio (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (clip_valid),
      .clip     (clip),
      .out_tag  (ratio_tag),
      .ratio_a  (ratio_a),
      .ratio_r  (ratio_r),
      .w_out    (ratio_w)
   );

   wsp_pixel u_pixel (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_tag      (ratio_tag),
      .ratio_a     (ratio_a),
      .ratio_r     (ratio_r),
      .w_in        (ratio_w),
      .res         ({height_ff, width_ff}),
      .out_valid   (out_valid),
      .out_visible (rsp_chan.visible),
      .screen_x    (rsp_chan.screen_x),
      .screen_y    (rsp_chan.screen_y)
   );

   assign rsp_chan.valid = out_valid;

   // Points behind the camera carry zero coordinates
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.visible |->
         rsp_chan.screen_x == '0 && rsp_chan.screen_y == '0)
      else $error("hidden point with nonzero coordinates");

   // A held result blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request accepted while result held");

   // Reset empties the output stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid after reset");

endmodule
